// ----- rtl/msbag_pkg.sv -----
// Package for the multiset bag table: sizes, action codes and transaction types.
// Used by the table and the checker; depends on nothing else.
package msbag_pkg;

    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 16;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ACTION_W   = 2;
    localparam int LIMIT_W    = 5;
    localparam int OUT_CNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COUNT  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [ITEM_WIDTH-1:0] item_value;
    } msbag_req_t;

    typedef struct packed {
        logic                 success;
        logic                 add_rejected;
        logic [OUT_CNT_W-1:0] match_count;
        logic [OUT_CNT_W-1:0] item_count;
        logic                 is_full;
        logic                 is_empty;
    } msbag_rsp_t;

endpackage

// ----- rtl/multiset_bag_table.sv -----
// Multiset bag table: add, remove-first-match, count and clear on a bounded bag.
// Add and clear finish in the accept cycle and set a pending flag; the result moves to the
// output register when that is free, so they sustain one transaction per cycle while the
// output is not stalled. Remove and count scan the stored entries through one RAM read port
// and one comparator; a remove that hits before the last entry copies the last entry there.
// Reset clears control state and count and sets the limit to 16; the entry RAM is not reset.
module multiset_bag_table
    import msbag_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  msbag_req_t         req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output msbag_rsp_t         rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    // Sequencer states. The scan state walks the stored entries; the move and write
    // states copy the last entry into the slot that a remove has freed.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_MOVE  = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [ACTION_W-1:0]   act_reg, act_next;
    logic [ITEM_WIDTH-1:0] item_reg, item_next;
    logic [CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [ADDR_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]      match_reg, match_next;
    logic                  succ_reg, succ_next;
    logic                  rej_reg, rej_next;
    logic                  pend_reg, pend_next;
    logic                  rsp_valid_reg;
    msbag_rsp_t            rsp_reg;

    logic [CNT_W-1:0]      eff_lim;
    logic [CNT_W-1:0]      last_idx;
    logic                  out_load;
    logic                  accept;
    logic                  hit;
    logic                  is_last;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    msbag_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ITEM_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The limit register is to be changed only while idle; this is not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // A limit of zero behaves as one, and a limit above the store depth as the depth.
    always_comb
    begin
        if (limit_reg == '0)
        begin
            eff_lim = CNT_W'(1);
        end
        else if (int'(limit_reg) > DEPTH)
        begin
            eff_lim = CNT_W'(DEPTH);
        end
        else
        begin
            eff_lim = CNT_W'(limit_reg);
        end
    end

    // A finished result waits in the pending flags until the output register is free.
    // A new request is taken in the same cycle that the pending result moves out.
    assign out_load  = pend_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = (state_reg == S_IDLE) && (!pend_reg || out_load);
    assign accept    = req_valid && req_ready;

    assign last_idx = count_reg - CNT_W'(1);
    assign hit      = (ram_rdata == item_reg);
    assign is_last  = (CNT_W'(cmp_idx_reg) == last_idx);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        act_next      = act_reg;
        item_next     = item_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        hit_idx_next  = hit_idx_reg;
        match_next    = match_reg;
        succ_next     = succ_reg;
        rej_next      = rej_reg;
        pend_next     = pend_reg && !out_load;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[ADDR_W-1:0];
        ram_wdata     = req.item_value;
        ram_raddr     = scan_idx_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next   = req.action;
                    item_next  = req.item_value;
                    match_next = '0;
                    succ_next  = 1'b0;
                    rej_next   = 1'b0;
                    case (req.action)
                        ACT_ADD:
                        begin
                            pend_next = 1'b1;
                            if (count_reg >= eff_lim)
                            begin
                                rej_next = 1'b1;
                            end
                            else
                            begin
                                // The count is below the limit, so it is a valid index.
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                succ_next  = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            // Entries stay in place; only the count goes back to zero.
                            count_next = '0;
                            pend_next  = 1'b1;
                        end
                        default:
                        begin
                            // Remove and count both walk the stored entries.
                            if (count_reg == '0)
                            begin
                                pend_next = 1'b1;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Issue the next read while comparing the data of the previous one.
                if (scan_idx_reg < count_reg)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[ADDR_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if ((act_reg == ACT_REMOVE) && hit)
                    begin
                        hit_idx_next = cmp_idx_reg;
                        succ_next    = 1'b1;
                        if (is_last)
                        begin
                            count_next = last_idx;
                            pend_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_MOVE;
                        end
                    end
                    else
                    begin
                        if ((act_reg == ACT_COUNT) && hit)
                        begin
                            match_next = match_reg + CNT_W'(1);
                        end
                        if (is_last)
                        begin
                            pend_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_MOVE:
            begin
                ram_raddr  = last_idx[ADDR_W-1:0];
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hit_idx_reg;
                ram_wdata  = ram_rdata;
                count_next = last_idx;
                pend_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        item_reg     <= item_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        match_reg    <= match_next;
        succ_reg     <= succ_next;
        rej_reg      <= rej_next;
    end

    // Output register. The count has already been updated when the result moves here,
    // so the size and the full and empty flags are taken from the live count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_reg.success      <= succ_reg;
            rsp_reg.add_rejected <= rej_reg;
            rsp_reg.match_count  <= OUT_CNT_W'(match_reg);
            rsp_reg.item_count   <= OUT_CNT_W'(count_reg);
            rsp_reg.is_full      <= (count_reg >= eff_lim);
            rsp_reg.is_empty     <= (count_reg == '0);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/msbag_ram.sv -----
// Simple single-port-write, single-port-read RAM with registered read data.
// Holds the bag entries; depends on nothing else.
module msbag_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/msbag_checker.sv -----
// Port-level checks for the multiset bag table, bound to the top level.
// Depends on msbag_pkg for the response transaction type.
module msbag_checker
    import msbag_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input msbag_rsp_t rsp
);

    // A response transaction that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // The empty flag agrees with the reported size.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.item_count == '0)))
        else $error("empty flag disagrees with item count");

    // A request cannot both succeed and be rejected.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.success && rsp.add_rejected))
        else $error("success and rejection both set");

    // Only a count reports matches, and a count never reports success or rejection.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.match_count != '0) |-> !rsp.success && !rsp.add_rejected)
        else $error("match count reported on a non-count request");

    // An empty bag cannot be full, since the limit is at least one.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |-> !rsp.is_full)
        else $error("bag reported both empty and full");

endmodule

bind multiset_bag_table msbag_checker u_msbag_checker (.*);
